>>> rtl/sparse_set_handle_table_defines.svh
// assertion macros for the handle table rtl
// needs signals named clock and reset in the module that uses them
`ifndef SPARSE_SET_HANDLE_TABLE_DEFINES_SVH
`define SPARSE_SET_HANDLE_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SST_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("handle table check failed");

// next-cycle implication, checked out of reset
`define SST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("handle table check failed");

`endif

>>> rtl/sst_pkg.sv
// shared types and constants of the sparse-set handle table
// no dependencies
package sst_pkg;

   localparam int MAX_HANDLES = 256;
   localparam int HANDLE_W    = 8;
   localparam int SLOT_W      = 8;
   localparam int PAY_W       = 32;
   localparam int COUNT_W     = 9;
   localparam int DENSE_W     = PAY_W + HANDLE_W;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CREATE,
      S_CHECK,
      S_READ,
      S_MOVE,
      S_UNLINK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [HANDLE_W-1:0] handle;
      logic [PAY_W-1:0]    entity_id;
   } request_type;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic [SLOT_W-1:0]   slot;
      logic [PAY_W-1:0]    payload;
      logic [COUNT_W-1:0]  live_count;
   } result_type;

endpackage

>>> rtl/sst_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/sst_ctrl.sv
// sequencer of the handle table: counters, valid bits, handle and dense memories
// depends on sst_pkg, sst_ram and the assertion macro header
`include "sparse_set_handle_table_defines.svh"
module sst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  sst_pkg::request_type req,
   output logic                ready,
   output logic                res_valid,
   output sst_pkg::result_type res,
   input  logic                res_take
);
   import sst_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [HANDLE_W-1:0] hin_ff, hin_in;
   logic [PAY_W-1:0]    id_ff, id_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [PAY_W-1:0]    pay_ff, pay_in;
   logic [HANDLE_W-1:0] head_ff, head_in;
   logic [COUNT_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [COUNT_W-1:0]  live_ff, live_in;
   logic [COUNT_W-1:0]  issued_ff, issued_in;
   result_type          res_ff, res_in;
   logic                valid_ff [MAX_HANDLES];
   logic                valid_set, valid_clr;
   logic [HANDLE_W-1:0] valid_idx;

   // memory ports
   logic                h_we;
   logic [HANDLE_W-1:0] h_waddr, h_raddr;
   logic [SLOT_W-1:0]   h_wdata, hrd;
   logic                d_we;
   logic [SLOT_W-1:0]   d_waddr, d_raddr;
   logic [DENSE_W-1:0]  d_wdata, drd;

   logic                accept;
   logic                check_bad;
   logic                use_free;
   logic                create_full;
   logic [HANDLE_W-1:0] new_h;
   logic [SLOT_W-1:0]   live_idx, last_idx;

   // handle memory: dense slot of a live handle, next free handle of a freed one
   sst_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_HANDLES)) u_hmap (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (h_raddr),
      .rdata (hrd)
   );

   // dense memory: payload and owning handle per slot
   sst_ram #(.WIDTH(DENSE_W), .DEPTH(MAX_HANDLES)) u_dense (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (drd)
   );

   // handshake and decisions
   assign ready       = (state_ff == S_IDLE);
   assign accept      = req.valid && ready;
   assign res_valid   = (state_ff == S_RESP);
   assign res         = res_ff;
   assign use_free    = (free_cnt_ff != '0);
   assign create_full = (live_ff == COUNT_W'(MAX_HANDLES)) ||
                        (!use_free && issued_ff == COUNT_W'(MAX_HANDLES));
   assign new_h       = use_free ? head_ff : issued_ff[HANDLE_W-1:0];
   assign live_idx    = live_ff[SLOT_W-1:0];
   assign last_idx    = live_idx - SLOT_W'(1);
   assign check_bad   = (op_ff == OP_UNUSED) || !valid_ff[hin_ff] ||
                        ({1'b0, hin_ff} >= issued_ff) || (live_ff == '0) ||
                        ({1'b0, hrd} >= live_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req.op == OP_CREATE) ? S_CREATE : S_CHECK;
            end
         end
         S_CREATE: state_in = S_RESP;
         S_CHECK:  state_in = check_bad ? S_RESP : S_READ;
         S_READ:   state_in = (op_ff == OP_LOOKUP) ? S_RESP : S_MOVE;
         S_MOVE:   state_in = S_UNLINK;
         S_UNLINK: state_in = S_RESP;
         S_RESP: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory control per state
   always_comb begin
      op_in       = op_ff;
      hin_in      = hin_ff;
      id_in       = id_ff;
      slot_in     = slot_ff;
      pay_in      = pay_ff;
      head_in     = head_ff;
      free_cnt_in = free_cnt_ff;
      live_in     = live_ff;
      issued_in   = issued_ff;
      res_in      = res_ff;
      valid_set   = 1'b0;
      valid_clr   = 1'b0;
      valid_idx   = hin_ff;
      h_we        = 1'b0;
      h_waddr     = hin_ff;
      h_wdata     = slot_ff;
      h_raddr     = hin_ff;
      d_we        = 1'b0;
      d_waddr     = slot_ff;
      d_wdata     = drd;
      d_raddr     = hrd;
      unique case (state_ff)
         S_IDLE: begin
            // create peeks at the free list head, others fetch the handle's slot
            h_raddr = (req.op == OP_CREATE) ? head_ff : req.handle;
            if (accept) begin
               op_in  = req.op;
               hin_in = req.handle;
               id_in  = req.entity_id;
            end
         end
         S_CREATE: begin
            res_in.live_count = live_ff;
            res_in.payload    = '0;
            if (create_full) begin
               res_in.status = ST_FULL;
               res_in.handle = '0;
               res_in.slot   = '0;
            end else begin
               res_in.status     = ST_OK;
               res_in.handle     = new_h;
               res_in.slot       = live_idx;
               res_in.live_count = live_ff + COUNT_W'(1);
               d_we      = 1'b1;
               d_waddr   = live_idx;
               d_wdata   = {id_ff, new_h};
               h_we      = 1'b1;
               h_waddr   = new_h;
               h_wdata   = live_idx;
               valid_set = 1'b1;
               valid_idx = new_h;
               live_in   = live_ff + COUNT_W'(1);
               if (use_free) begin
                  head_in     = hrd;
                  free_cnt_in = free_cnt_ff - COUNT_W'(1);
               end else begin
                  issued_in = issued_ff + COUNT_W'(1);
               end
            end
         end
         S_CHECK: begin
            d_raddr = hrd;
            slot_in = hrd;
            if (check_bad) begin
               res_in.status     = ST_INVALID;
               res_in.handle     = hin_ff;
               res_in.slot       = '0;
               res_in.payload    = '0;
               res_in.live_count = live_ff;
            end
         end
         S_READ: begin
            // payload of the slot is here, fetch the last entry for a delete
            pay_in  = drd[DENSE_W-1:HANDLE_W];
            d_raddr = last_idx;
            res_in.status     = ST_OK;
            res_in.handle     = hin_ff;
            res_in.slot       = slot_ff;
            res_in.payload    = drd[DENSE_W-1:HANDLE_W];
            res_in.live_count = live_ff;
         end
         S_MOVE: begin
            // last entry moves into the freed slot, its handle follows
            d_we    = 1'b1;
            d_waddr = slot_ff;
            d_wdata = drd;
            h_we    = 1'b1;
            h_waddr = drd[HANDLE_W-1:0];
            h_wdata = slot_ff;
         end
         S_UNLINK: begin
            // push the handle on the free list, link kept in the handle memory
            h_we        = 1'b1;
            h_waddr     = hin_ff;
            h_wdata     = head_ff;
            valid_clr   = 1'b1;
            valid_idx   = hin_ff;
            head_in     = hin_ff;
            free_cnt_in = free_cnt_ff + COUNT_W'(1);
            live_in     = live_ff - COUNT_W'(1);
            res_in.status     = ST_OK;
            res_in.handle     = hin_ff;
            res_in.slot       = slot_ff;
            res_in.payload    = pay_ff;
            res_in.live_count = live_ff - COUNT_W'(1);
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         free_cnt_ff <= '0;
         live_ff     <= '0;
         issued_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         free_cnt_ff <= free_cnt_in;
         live_ff     <= live_in;
         issued_ff   <= issued_in;
      end
   end

   // per-handle valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_HANDLES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (valid_set) begin
         valid_ff[valid_idx] <= 1'b1;
      end else if (valid_clr) begin
         valid_ff[valid_idx] <= 1'b0;
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      hin_ff  <= hin_in;
      id_ff   <= id_in;
      slot_ff <= slot_in;
      pay_ff  <= pay_in;
      res_ff  <= res_in;
   end

   // checks
   `SST_ASSERT_IMPL(a_live_range, 1'b1, live_ff <= COUNT_W'(MAX_HANDLES))
   `SST_ASSERT_IMPL(a_count_balance, 1'b1,
      ({1'b0, free_cnt_ff} + {1'b0, live_ff}) == {1'b0, issued_ff})
   `SST_ASSERT_NEXT(a_unlink_dec, state_ff == S_UNLINK,
      live_ff == $past(live_ff) - COUNT_W'(1))
   `SST_ASSERT_IMPL(a_full_means_full, state_ff == S_RESP && res_ff.status == ST_FULL,
      live_ff == COUNT_W'(MAX_HANDLES) && free_cnt_ff == '0)

endmodule

>>> rtl/sparse_set_handle_table.sv
// Sparse-set handle table. Create hands out a handle (the most recently freed
// one first, else a new one) and appends the payload id to the dense array;
// delete moves the last dense entry into the freed slot; lookup returns the
// stored payload id. Requests are taken one at a time: a new item is taken
// only once the result of the last one has moved into the output register.
// Create passes through S_CREATE, a rejected delete or lookup through S_CHECK,
// lookup through S_CHECK and S_READ, delete through S_CHECK, S_READ, S_MOVE
// and S_UNLINK, as dependent reads go through the registered handle and dense
// memories, each with a single read port. Status 1 means the table is full,
// status 2 an invalid or dead handle (also the answer to the unused op code).
// Reset needs no clearing pass: handle valid bits live in flip-flops.
// Depends on sst_pkg and sst_ctrl.
module sparse_set_handle_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // handle_in [7:0], entity_id [39:8]
   input  logic [1:0]  req_tuser,   // op [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // handle_out [7:0], slot [15:8], payload [47:16],
                                    // live_count [56:48], zero fill [63:57]
   output logic [1:0]  rsp_tuser    // status [1:0]
);
   import sst_pkg::*;

   request_type req;
   result_type  res;
   logic        res_valid;
   logic        res_take;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   result_type  rsp_data_ff;

   // unpack the request item
   assign req.valid     = req_tvalid;
   assign req.op        = op_type'(req_tuser);
   assign req.handle    = req_tdata[HANDLE_W-1:0];
   assign req.entity_id = req_tdata[HANDLE_W +: PAY_W];

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .ready     (req_tready),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   // output register, loads when empty or being drained
   assign res_take      = res_valid && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid_in = res_take ? 1'b1 : (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   // pack the result item
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {7'd0, rsp_data_ff.live_count, rsp_data_ff.payload,
                        rsp_data_ff.slot, rsp_data_ff.handle};

endmodule

>>> test/tb.sv
// testbench for the sparse-set handle table: random create, delete and lookup
// traffic checked against a predictor of handles, dense slots and payload ids
// depends on sst_pkg and the sparse_set_handle_table rtl
module tb;
   import sst_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TOTAL_ITEMS  = 1900;
   localparam int IDLE_PCT     = 12;
   localparam int HOLD_AT_ITEM = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_FIRST   = 1000;
   localparam int CALM_LAST    = 1300;

   typedef struct {
      bit               drain;
      op_type           op;
      logic [7:0]       handle;
      logic [31:0]      id;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // handle_in [7:0], entity_id [39:8]
   logic [1:0]  req_tuser = '0;   // op [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // handle_out [7:0], slot [15:8], payload [47:16],
                                  // live_count [56:48]
   logic [1:0]  rsp_tuser;        // status [1:0]

   pending_type pending[$];
   result_type  expected_results[$];
   int          items_sent = 0;
   int          results_seen = 0;
   int          mismatches = 0;
   int          cycles = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   // predictor state of the table
   bit          tbl_valid[MAX_HANDLES];
   logic [7:0]  tbl_slot[MAX_HANDLES];
   logic [31:0] tbl_payload[MAX_HANDLES];
   logic [7:0]  tbl_owner[MAX_HANDLES];
   logic [7:0]  tbl_free[MAX_HANDLES];
   int          tbl_free_top = 0;
   int          tbl_live = 0;
   int          tbl_issued = 0;

   // generator's view of which handles are live, to aim deletes and lookups
   bit          g_live[MAX_HANDLES];
   int          g_free[$];
   int          g_issued = 0;
   int          g_count = 0;
   int          n_items = 0;

   sparse_set_handle_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // expected result of one item, updating the table state
   function automatic result_type table_step(op_type op, logic [7:0] h_in,
                                             logic [31:0] id);
      result_type res;
      logic [7:0] h;
      logic [7:0] sl;
      logic [7:0] lh;
      int         last;
      res.status  = ST_INVALID;
      res.handle  = h_in;
      res.slot    = '0;
      res.payload = '0;
      if (op == OP_CREATE) begin
         if (tbl_live >= MAX_HANDLES || (tbl_free_top == 0 && tbl_issued >= MAX_HANDLES)) begin
            res.status = ST_FULL;
            res.handle = '0;
         end else begin
            if (tbl_free_top > 0) begin
               tbl_free_top--;
               h = tbl_free[tbl_free_top];
            end else begin
               h = tbl_issued[7:0];
               tbl_issued++;
            end
            sl = tbl_live[7:0];
            tbl_payload[sl] = id;
            tbl_owner[sl]   = h;
            tbl_valid[h]    = 1'b1;
            tbl_slot[h]     = sl;
            tbl_live++;
            res.status = ST_OK;
            res.handle = h;
            res.slot   = sl;
         end
      end else if (op != OP_UNUSED && h_in < tbl_issued && tbl_valid[h_in] &&
                   tbl_slot[h_in] < tbl_live) begin
         sl = tbl_slot[h_in];
         res.status  = ST_OK;
         res.slot    = sl;
         res.payload = tbl_payload[sl];
         if (op == OP_DELETE) begin
            // last dense entry moves into the freed slot
            last = tbl_live - 1;
            lh   = tbl_owner[last];
            tbl_payload[sl] = tbl_payload[last];
            tbl_owner[sl]   = lh;
            tbl_slot[lh]    = sl;
            tbl_valid[h_in] = 1'b0;
            tbl_free[tbl_free_top] = h_in;
            tbl_free_top++;
            tbl_live--;
         end
      end
      res.live_count = tbl_live[8:0];
      return res;
   endfunction

   function automatic void add_item(op_type op, logic [7:0] h, logic [31:0] id);
      pending_type it;
      int          nh;
      it.drain  = 1'b0;
      it.op     = op;
      it.handle = h;
      it.id     = id;
      pending.push_back(it);
      n_items++;
      if (op == OP_CREATE && g_count < MAX_HANDLES) begin
         if (g_free.size() > 0) begin
            nh = g_free.pop_back();
         end else begin
            nh = g_issued;
            g_issued++;
         end
         g_live[nh] = 1'b1;
         g_count++;
      end else if (op == OP_DELETE && g_live[h]) begin
         g_live[h] = 1'b0;
         g_free.push_back(int'(h));
         g_count--;
      end
   endfunction

   // sender waits here until every outstanding result has come back
   function automatic void add_pause();
      pending_type it;
      it.drain  = 1'b1;
      it.op     = OP_CREATE;
      it.handle = '0;
      it.id     = '0;
      pending.push_back(it);
   endfunction

   function automatic logic [7:0] pick_live();
      int h;
      if (g_count == 0) return 8'($urandom);
      do h = $urandom_range(g_issued - 1); while (!g_live[h]);
      return h[7:0];
   endfunction

   // mostly well-formed traffic on live handles, a little noise
   function automatic void add_random(int create_pct, int delete_pct);
      if ($urandom_range(99) < 8)
         add_item(op_type'($urandom_range(3)), 8'($urandom), $urandom);
      else if (g_count == 0 || $urandom_range(99) < create_pct)
         add_item(OP_CREATE, 8'($urandom), $urandom);
      else if ($urandom_range(99) < delete_pct)
         add_item(OP_DELETE, pick_live(), $urandom);
      else
         add_item(OP_LOOKUP, pick_live(), $urandom);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
      end
   endfunction

   // driver: offers pending items, predicts each one as it is accepted
   always @(posedge clock) begin
      pending_type nxt;
      bit          offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(table_step(op_type'(req_tuser), req_tdata[7:0],
                                                  req_tdata[39:8]));
            items_sent <= items_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (pending.size() > 0 && pending[0].drain) begin
               if (expected_results.size() == 0) void'(pending.pop_front());
            end else if (pending.size() > 0 &&
                         ((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
                          $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending.pop_front();
               offer = 1'b1;
               req_tdata <= {nxt.id, nxt.handle};
               req_tuser <= nxt.op;
            end
            req_tvalid <= offer;
         end
      end
   end

   // long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_sent == HOLD_AT_ITEM) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // monitor: compares each result with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("result with no item outstanding");
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("handle", 32'(want.handle), 32'(rsp_tdata[7:0]));
               check_field("slot", 32'(want.slot), 32'(rsp_tdata[15:8]));
               check_field("payload", want.payload, rsp_tdata[47:16]);
               check_field("live_count", 32'(want.live_count), 32'(rsp_tdata[56:48]));
            end
            results_seen <= results_seen + 1;
         end
         rsp_tready <= hold_left == 0 &&
                       ((results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                        $urandom_range(99) >= IDLE_PCT);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MAX_HANDLES; i++) begin
         tbl_valid[i] = 1'b0;
         g_live[i]    = 1'b0;
      end

      // directed: bad handles on an empty table, extremes of the payload,
      // moving the last entry, reuse from the free stack, unused op
      add_item(OP_LOOKUP, 8'h00, 32'h0);
      add_item(OP_DELETE, 8'hFF, 32'hFFFF_FFFF);
      add_item(OP_UNUSED, 8'hA5, 32'h0);
      add_item(OP_CREATE, 8'h00, 32'h0000_0000);
      add_item(OP_CREATE, 8'hFF, 32'hFFFF_FFFF);
      add_item(OP_CREATE, 8'h5A, 32'hA5A5_5A5A);
      add_item(OP_LOOKUP, 8'h00, 32'h0);
      add_item(OP_LOOKUP, 8'h01, 32'h0);
      add_item(OP_LOOKUP, 8'h02, 32'h0);
      add_item(OP_DELETE, 8'h00, 32'h0);
      add_item(OP_LOOKUP, 8'h02, 32'h0);
      add_item(OP_DELETE, 8'h00, 32'h0);
      add_item(OP_LOOKUP, 8'h00, 32'h0);
      add_item(OP_CREATE, 8'h00, 32'h5A5A_A5A5);
      add_item(OP_DELETE, 8'h00, 32'h0);
      add_item(OP_LOOKUP, 8'h01, 32'h0);
      add_item(OP_DELETE, 8'h01, 32'h0);
      add_item(OP_DELETE, 8'h02, 32'h0);
      add_item(OP_LOOKUP, 8'h02, 32'h0);
      add_item(OP_UNUSED, 8'h00, 32'hFFFF_FFFF);
      add_item(OP_CREATE, 8'h00, 32'h1234_5678);
      add_pause();

      // mixed traffic at low occupancy
      repeat (400) add_random(45, 50);
      add_pause();

      // fill the table, then push against the full case
      while (g_count < MAX_HANDLES) add_random(85, 30);
      repeat (4) add_item(OP_CREATE, 8'($urandom), $urandom);
      add_item(OP_LOOKUP, 8'hFF, 32'h0);
      add_item(OP_DELETE, 8'hFF, 32'h0);
      add_item(OP_CREATE, 8'h00, 32'hFFFF_FFFF);
      add_item(OP_CREATE, 8'h00, 32'h0);
      repeat (150) add_random(50, 60);
      add_pause();

      // drain it back to empty
      while (g_count > 0) add_random(15, 80);
      add_pause();

      // mixed traffic for the rest
      while (n_items < TOTAL_ITEMS) add_random(50, 50);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
